// ===== sv/icon_state_pixel_variants_macros.svh =====
// ----------------------------------------------------------------------------
// icon_state_pixel_variants_macros
// Assertion macros for the checker file of the pixel variant block.
// ----------------------------------------------------------------------------
`ifndef ICON_STATE_PIXEL_VARIANTS_MACROS_SVH
`define ICON_STATE_PIXEL_VARIANTS_MACROS_SVH

// property must hold at every clock edge outside reset
`define ISV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("isv assertion failed");

// condition must never be seen outside reset
`define ISV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("isv forbidden condition seen");

`endif

// ===== sv/isv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_pkg
// Types, register codes and fixed-point helpers for the pixel variant block.
// ----------------------------------------------------------------------------
package isv_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 32;

  localparam logic [11:0] GREY_DIS     = 12'd648;  // 216 * 3
  localparam logic [11:0] GREY_DIS_PRS = 12'd564;  // 188 * 3
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  typedef enum logic {
    REG_ALPHA_MODE     = 1'b0,
    REG_VARIANT_ENABLE = 1'b1
  } isv_reg_e;

  typedef struct packed {
    logic       alpha_mode;
    logic [1:0] variant_enable;
  } isv_cfg_t;

  localparam int unsigned EN_DIS_BIT = 0;
  localparam int unsigned EN_PRS_BIT = 1;

  // floor(x / 5), exact for x < 1280
  function automatic logic [7:0] div5_f(input logic [11:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'd13108;
    return prod[23:16];
  endfunction

  // floor(x / 10), exact for x < 2560
  function automatic logic [7:0] div10_f(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'd6554;
    return prod[23:16];
  endfunction

  // floor(x / 100), exact for x < 25600
  function automatic logic [7:0] div100_f(input logic [14:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'd5243;
    return prod[26:19];
  endfunction

  function automatic logic [31:0] pack_f(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] a);
    return {a, b2, b1, b0};
  endfunction

endpackage

// ===== sv/isv_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_cfg_regs
// APB register file holding the mode and variant enable registers.
// ----------------------------------------------------------------------------
module isv_cfg_regs
  import isv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output isv_cfg_t          cfg_o
);

  isv_cfg_t cfg_q, cfg_d;
  isv_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = isv_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ALPHA_MODE:     cfg_d.alpha_mode     = pwdata[0];
        REG_VARIANT_ENABLE: cfg_d.variant_enable = pwdata[1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ALPHA_MODE:     prdata = {{(DATA_W-1){1'b0}}, cfg_q.alpha_mode};
      REG_VARIANT_ENABLE: prdata = {{(DATA_W-2){1'b0}}, cfg_q.variant_enable};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/isv_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_calc
// Combinational pixel math: normal, pressed, disabled and disabled-pressed.
// ----------------------------------------------------------------------------
module isv_calc
  import isv_pkg::*;
(
  input  isv_cfg_t          cfg_i,
  input  logic [CHAN_W-1:0] chan0_i,
  input  logic [CHAN_W-1:0] chan1_i,
  input  logic [CHAN_W-1:0] chan2_i,
  input  logic [CHAN_W-1:0] alpha_i,
  output logic [PIX_W-1:0]  normal_o,
  output logic [PIX_W-1:0]  pressed_o,
  output logic [PIX_W-1:0]  disabled_o,
  output logic [PIX_W-1:0]  dis_prs_o
);

  logic [CHAN_W-1:0] c [3];
  logic [CHAN_W-1:0] p [3];
  logic [CHAN_W-1:0] d [3];
  logic [CHAN_W-1:0] x [3];
  logic [14:0]       grey_sum;
  logic [7:0]        grey;
  logic [CHAN_W-1:0] alpha_out;
  logic [CHAN_W-1:0] dis_alpha;
  logic              dis_on;
  logic              prs_on;

  assign c[0] = chan0_i;
  assign c[1] = chan1_i;
  assign c[2] = chan2_i;

  assign dis_on = cfg_i.variant_enable[EN_DIS_BIT];
  assign prs_on = cfg_i.variant_enable[EN_PRS_BIT];

  // 10/60/30 weighted grey
  assign grey_sum = 15'(c[0]) * 15'd10 + 15'(c[1]) * 15'd60 + 15'(c[2]) * 15'd30;
  assign grey     = div100_f(grey_sum);

  assign alpha_out = cfg_i.alpha_mode ? alpha_i : ALPHA_OPAQUE;
  assign dis_alpha = cfg_i.alpha_mode ? div10_f(12'(alpha_i) * 12'd3) : ALPHA_OPAQUE;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = div5_f({2'b00, c[i], 2'b00});
      if (cfg_i.alpha_mode) begin
        d[i] = div10_f(12'(grey) * 12'd7 + 12'(c[i]) * 12'd3);
        x[i] = div5_f({2'b00, d[i], 2'b00});
      end else begin
        d[i] = div5_f(GREY_DIS + {3'b000, c[i], 1'b0});
        x[i] = div5_f(GREY_DIS_PRS + {3'b000, c[i], 1'b0});
      end
    end
  end

  assign normal_o   = pack_f(c[0], c[1], c[2], alpha_out);
  assign pressed_o  = prs_on ? pack_f(p[0], p[1], p[2], alpha_out) : '0;
  assign disabled_o = dis_on ? pack_f(d[0], d[1], d[2], dis_alpha) : '0;
  assign dis_prs_o  = (dis_on && prs_on) ? pack_f(x[0], x[1], x[2], dis_alpha) : '0;

endmodule

// ===== sv/icon_state_pixel_variants.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_state_pixel_variants
// Derives normal, pressed, disabled and disabled-pressed pixels from one
// source pixel per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a beat of chan0/chan1/chan2/alpha_in is taken on each
//   rising edge with start high and busy low. busy is always low, so a new
//   pixel can be taken every cycle.
//   Result channel: done_o is high for one cycle with the four packed pixels
//   (byte0 lowest, alpha highest). The receiver cannot stall; every result
//   must be taken in the cycle it is shown.
//   Pipeline: input register, then result register. Throughput: one pixel
//   per cycle, set by the single combinational pass between the two
//   registers.
//   Configuration: APB port, alpha_mode at address 0, variant_enable at 4.
//   Writes only while no pixel is in flight.
//   Reset: both registers clear to 0 (opaque mode, no variants), pipeline
//   valid bits clear, so no result is shown until a pixel is taken.
// ----------------------------------------------------------------------------
module icon_state_pixel_variants
  import isv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] chan0_i,
  input  logic [CHAN_W-1:0] chan1_i,
  input  logic [CHAN_W-1:0] chan2_i,
  input  logic [CHAN_W-1:0] alpha_in_i,
  output logic              done_o,
  output logic [PIX_W-1:0]  normal_pixel_o,
  output logic [PIX_W-1:0]  pressed_pixel_o,
  output logic [PIX_W-1:0]  disabled_pixel_o,
  output logic [PIX_W-1:0]  disabled_pressed_pixel_o
);

  isv_cfg_t          cfg;
  logic              vld_q;
  logic [CHAN_W-1:0] c0_q, c1_q, c2_q, a_q;
  logic              done_q;
  logic [PIX_W-1:0]  normal_d, pressed_d, disabled_d, dis_prs_d;
  logic [PIX_W-1:0]  normal_q, pressed_q, disabled_q, dis_prs_q;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  isv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c0_q <= chan0_i;
      c1_q <= chan1_i;
      c2_q <= chan2_i;
      a_q  <= alpha_in_i;
    end
  end

  isv_calc u_calc (
    .cfg_i      (cfg),
    .chan0_i    (c0_q),
    .chan1_i    (c1_q),
    .chan2_i    (c2_q),
    .alpha_i    (a_q),
    .normal_o   (normal_d),
    .pressed_o  (pressed_d),
    .disabled_o (disabled_d),
    .dis_prs_o  (dis_prs_d)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      normal_q   <= normal_d;
      pressed_q  <= pressed_d;
      disabled_q <= disabled_d;
      dis_prs_q  <= dis_prs_d;
    end
  end

  assign done_o                   = done_q;
  assign normal_pixel_o           = normal_q;
  assign pressed_pixel_o          = pressed_q;
  assign disabled_pixel_o         = disabled_q;
  assign disabled_pressed_pixel_o = dis_prs_q;

endmodule

// ===== sv/isv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_checker
// Port-level checks for the pixel variant block, bound to the top level.
// ----------------------------------------------------------------------------
`include "icon_state_pixel_variants_macros.svh"

module isv_checker
  import isv_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [PIX_W-1:0] normal_pixel_o,
  input logic [PIX_W-1:0] pressed_pixel_o,
  input logic [PIX_W-1:0] disabled_pixel_o,
  input logic [PIX_W-1:0] disabled_pressed_pixel_o
);

  // every accepted beat yields a result through the input and result registers
  `ISV_ASSERT(a_beat_to_result, clk_i, rst_ni, (start && !busy) |=> ##1 done_o)

  // no result without a beat taken earlier through both registers
  `ISV_ASSERT(a_no_stray_result, clk_i, rst_ni, done_o |-> $past(start && !busy, 2))

  // pressed pixel carries the normal alpha and its byte0 never brightens
  `ISV_ASSERT_NEVER(a_pressed_alpha, clk_i, rst_ni,
    done_o && pressed_pixel_o != '0 &&
    (pressed_pixel_o[31:24] != normal_pixel_o[31:24] ||
     pressed_pixel_o[7:0] > normal_pixel_o[7:0]))

  // disabled-pressed shares the disabled alpha
  `ISV_ASSERT_NEVER(a_dis_prs_alpha, clk_i, rst_ni,
    done_o && disabled_pressed_pixel_o != '0 &&
    disabled_pressed_pixel_o[31:24] != disabled_pixel_o[31:24])

endmodule

bind icon_state_pixel_variants isv_checker u_isv_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .start                    (start),
  .busy                     (busy),
  .done_o                   (done_o),
  .normal_pixel_o           (normal_pixel_o),
  .pressed_pixel_o          (pressed_pixel_o),
  .disabled_pixel_o         (disabled_pixel_o),
  .disabled_pressed_pixel_o (disabled_pressed_pixel_o)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel variant block. Pixels go in as command
// beats through start/busy; registers are set over APB in between. A local
// predictor derives the normal, pressed, disabled and disabled-pressed
// pixels for each taken beat. Each done_o beat is compared field by field
// against the oldest prediction. The run holds a short corner set, every
// enable/mode setting and a random stream with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import isv_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] normal_px;
    logic [PIX_W-1:0] pressed_px;
    logic [PIX_W-1:0] disabled_px;
    logic [PIX_W-1:0] dis_pressed_px;
  } variants_t;

  localparam time RUN_LIMIT = 2ms;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] chan0_i = '0;
  logic [CHAN_W-1:0] chan1_i = '0;
  logic [CHAN_W-1:0] chan2_i = '0;
  logic [CHAN_W-1:0] alpha_in_i = '0;
  logic              done_o;
  logic [PIX_W-1:0]  normal_pixel_o;
  logic [PIX_W-1:0]  pressed_pixel_o;
  logic [PIX_W-1:0]  disabled_pixel_o;
  logic [PIX_W-1:0]  disabled_pressed_pixel_o;

  isv_cfg_t  cfg_shadow = '0;
  variants_t pending_variants[$];
  int unsigned n_fail = 0;
  int unsigned n_pixels = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 1;

  always #5 clk_i = ~clk_i;

  icon_state_pixel_variants u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .start                    (start),
    .busy                     (busy),
    .chan0_i                  (chan0_i),
    .chan1_i                  (chan1_i),
    .chan2_i                  (chan2_i),
    .alpha_in_i               (alpha_in_i),
    .done_o                   (done_o),
    .normal_pixel_o           (normal_pixel_o),
    .pressed_pixel_o          (pressed_pixel_o),
    .disabled_pixel_o         (disabled_pixel_o),
    .disabled_pressed_pixel_o (disabled_pressed_pixel_o)
  );

  function automatic variants_t predict_variants(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [7:0] c2, input logic [7:0] a);
    int unsigned chan[3];
    int unsigned grey;
    int unsigned dis[3];
    int unsigned dis_prs[3];
    int unsigned prs[3];
    logic [7:0]  alpha_out;
    logic [7:0]  dis_alpha;
    variants_t   v;
    chan[0] = c0;
    chan[1] = c1;
    chan[2] = c2;
    alpha_out = cfg_shadow.alpha_mode ? a : 8'd255;
    grey = (chan[0] * 10 + chan[1] * 60 + chan[2] * 30) / 100;
    for (int i = 0; i < 3; i++) begin
      prs[i] = chan[i] * 4 / 5;
      if (cfg_shadow.alpha_mode) begin
        dis[i] = (7 * grey + 3 * chan[i]) / 10;
        dis_prs[i] = dis[i] * 4 / 5;
      end else begin
        dis[i] = (648 + 2 * chan[i]) / 5;
        dis_prs[i] = (564 + 2 * chan[i]) / 5;
      end
    end
    dis_alpha = cfg_shadow.alpha_mode ? 8'((3 * int'(a)) / 10) : 8'd255;
    v = '0;
    v.normal_px = {alpha_out, c2, c1, c0};
    if (cfg_shadow.variant_enable[EN_PRS_BIT])
      v.pressed_px = {alpha_out, 8'(prs[2]), 8'(prs[1]), 8'(prs[0])};
    if (cfg_shadow.variant_enable[EN_DIS_BIT])
      v.disabled_px = {dis_alpha, 8'(dis[2]), 8'(dis[1]), 8'(dis[0])};
    if (cfg_shadow.variant_enable[EN_DIS_BIT] && cfg_shadow.variant_enable[EN_PRS_BIT])
      v.dis_pressed_px = {dis_alpha, 8'(dis_prs[2]), 8'(dis_prs[1]), 8'(dis_prs[0])};
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // result beats
  always @(posedge clk_i) begin
    variants_t v;
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (pending_variants.size() == 0) begin
        $error("unexpected result beat: normal_pixel %h", normal_pixel_o);
        n_fail++;
      end else begin
        v = pending_variants.pop_front();
        check_field("normal_pixel", v.normal_px, normal_pixel_o);
        check_field("pressed_pixel", v.pressed_px, pressed_pixel_o);
        check_field("disabled_pixel", v.disabled_px, disabled_pixel_o);
        check_field("disabled_pressed_pixel", v.dis_pressed_px, disabled_pressed_pixel_o);
      end
    end
  end

  task automatic apb_access(input isv_reg_e idx, input logic wr, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (wr) begin
      case (idx)
        REG_ALPHA_MODE:     cfg_shadow.alpha_mode = value[0];
        REG_VARIANT_ENABLE: cfg_shadow.variant_enable = value[1:0];
        default: ;
      endcase
    end else begin
      case (idx)
        REG_ALPHA_MODE:     check_field("alpha_mode", 32'(cfg_shadow.alpha_mode),
                                        32'(prdata[0]));
        REG_VARIANT_ENABLE: check_field("variant_enable", 32'(cfg_shadow.variant_enable),
                                        32'(prdata[1:0]));
        default: ;
      endcase
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every prediction to be matched, then let the pipe empty out
  task automatic wait_drained();
    while (pending_variants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // upper bits of each write are random noise the block must drop
  task automatic set_config(input logic mode, input logic [1:0] enables);
    wait_drained();
    apb_access(REG_ALPHA_MODE, 1'b1, {$urandom} & ~32'h1 | 32'(mode));
    apb_access(REG_VARIANT_ENABLE, 1'b1, {$urandom} & ~32'h3 | 32'(enables));
    apb_access(REG_ALPHA_MODE, 1'b0, '0);
    apb_access(REG_VARIANT_ENABLE, 1'b0, '0);
    n_settings++;
  endtask

  task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] a);
    @(negedge clk_i);
    start <= 1'b1;
    chan0_i <= c0;
    chan1_i <= c1;
    chan2_i <= c2;
    alpha_in_i <= a;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_variants.push_back(predict_variants(c0, c1, c2, a));
    n_pixels++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      chan0_i <= 8'($urandom);
      chan1_i <= 8'($urandom);
      chan2_i <= 8'($urandom);
      alpha_in_i <= 8'($urandom);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_corners();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd254);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    idle_cycles(1);
  endtask

  // reset values: opaque, no variants
  task automatic test_reset_state();
    apb_access(REG_ALPHA_MODE, 1'b0, '0);
    apb_access(REG_VARIANT_ENABLE, 1'b0, '0);
    send_pixel(8'd12, 8'd200, 8'd99, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0);
    idle_cycles(1);
  endtask

  task automatic test_corner_pixels();
    set_config(1'b0, 2'b11);
    send_corners();
    set_config(1'b1, 2'b11);
    send_corners();
  endtask

  task automatic test_variant_enables();
    set_config(1'b1, 2'b01);
    send_pixel(8'd255, 8'd128, 8'd3, 8'd255);
    send_pixel(8'd7, 8'd250, 8'd90, 8'd10);
    idle_cycles(1);
    set_config(1'b0, 2'b10);
    send_pixel(8'd255, 8'd128, 8'd3, 8'd255);
    send_pixel(8'd7, 8'd250, 8'd90, 8'd10);
    idle_cycles(1);
  endtask

  // sender holds off until every prediction has been matched, then resumes
  task automatic test_drain_pause();
    set_config(1'b1, 2'b11);
    repeat (20) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    idle_cycles(1);
    wait_drained();
    repeat (20) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    idle_cycles(1);
  endtask

  task automatic test_random_stream();
    logic [2:0] setting;
    bit         gaps_on;
    for (int phase = 0; phase < 12; phase++) begin
      setting = (phase < 8) ? 3'(phase) : 3'($urandom);
      gaps_on = (phase != 9);
      set_config(setting[2], setting[1:0]);
      repeat (97) begin
        send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        if (gaps_on && $urandom_range(0, 99) < 19) idle_cycles(1);
      end
      idle_cycles(1);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_corner_pixels();
    test_variant_enables();
    test_drain_pause();
    test_random_stream();
    wait_drained();
    $display("covered %0d pixels and %0d result beats", n_pixels, n_results);
    $display("over %0d register settings, both modes and all enable combinations", n_settings);
    if (n_fail == 0) begin
      $display("icon_state_pixel_variants verification clean");
    end else begin
      $display("icon_state_pixel_variants verification failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", pending_variants.size());
    $display("icon_state_pixel_variants verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/isv_pkg.sv
sv/isv_cfg_regs.sv
sv/isv_calc.sv
sv/icon_state_pixel_variants.sv
sv/isv_checker.sv
verif/tb_top.sv
